@@ design/gbs_pkg.sv @@
// Shared types, constants and configuration codes of the Gaussian background subtraction unit.
package gbs_pkg;

    localparam int unsigned NUM_PIXELS = 524288;
    localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    localparam int PIX_W      = 8;
    localparam int IDX_W      = 19;
    localparam int VAL_W      = 16;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [VAL_W-1:0] RST_LEARNING_RATE    = 16'd1311;
    localparam logic [THR_W-1:0] RST_MATCH_THRESHOLD  = 8'd13;
    localparam logic [VAL_W-1:0] RST_INITIAL_VARIANCE = 16'd9216;
    localparam logic [VAL_W-1:0] RST_VARIANCE_FLOOR   = 16'd1024;
    localparam logic [VAL_W-1:0] RST_VARIANCE_CEIL    = 16'd46080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE    = 3'd0,
        REG_MATCH_THRESHOLD  = 3'd1,
        REG_INITIAL_VARIANCE = 3'd2,
        REG_VARIANCE_FLOOR   = 3'd3,
        REG_VARIANCE_CEIL    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] pixel_index;
        logic             frame_end;
    } gbs_in_t;

    typedef struct packed {
        logic             foreground;
        logic [IDX_W-1:0] out_index;
    } gbs_out_t;

    typedef struct packed {
        logic [VAL_W-1:0] learning_rate;
        logic [THR_W-1:0] match_threshold;
        logic [VAL_W-1:0] initial_variance;
        logic [VAL_W-1:0] variance_floor;
        logic [VAL_W-1:0] variance_ceil;
    } gbs_cfg_t;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] pixel_index;
        logic             load;
        logic             wr_en;
    } gbs_cmd_t;

endpackage

@@ design/gbs_front.sv @@
// Front end: accepts input beats, classifies them by frame and range, and queues them.
module gbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gbs_pkg::gbs_in_t  in_data,
    output logic              head_valid,
    output gbs_pkg::gbs_cmd_t head,
    input  logic              pop
);

    gbs_pkg::gbs_cmd_t             queue_mem [gbs_pkg::QUEUE_DEPTH];
    logic [gbs_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [gbs_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [gbs_pkg::QPTR_W:0]      count_reg;
    logic [gbs_pkg::QPTR_W:0]      count_next;
    logic                          model_ready_reg;
    logic                          model_ready_next;
    logic                          push;
    gbs_pkg::gbs_cmd_t             cmd;

    always_comb
    begin
        in_stall   = (count_reg == (gbs_pkg::QPTR_W + 1)'(gbs_pkg::QUEUE_DEPTH));
        push       = in_valid && !in_stall;
        head_valid = (count_reg != '0);
        head       = queue_mem[rd_ptr_reg];

        // Pixels of the first frame only load the model.
        cmd.pixel       = in_data.pixel;
        cmd.pixel_index = in_data.pixel_index;
        cmd.load        = !model_ready_reg;
        cmd.wr_en       = (32'(in_data.pixel_index) < gbs_pkg::NUM_PIXELS);

        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end

        model_ready_next = model_ready_reg || (push && in_data.frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            model_ready_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg       <= count_next;
            model_ready_reg <= model_ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd;
        end
    end

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_push_grows_queue: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

@@ design/gbs_back.sv @@
// Back end: per-pixel model store and the pipelined mean/variance update and match test.
module gbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gbs_pkg::gbs_cfg_t cfg,
    input  logic              head_valid,
    input  gbs_pkg::gbs_cmd_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output gbs_pkg::gbs_out_t out_data
);

    localparam int STAGES = 5;

    logic [2*gbs_pkg::VAL_W-1:0] model_mem [gbs_pkg::NUM_PIXELS];
    logic [2*gbs_pkg::VAL_W-1:0] mem_rd_reg;

    gbs_pkg::gbs_cmd_t  cmd_reg [1:STAGES];
    logic [STAGES:1]    valid_reg;
    logic               out_valid_reg;
    gbs_pkg::gbs_out_t  out_data_reg;
    gbs_pkg::gbs_out_t  out_data_next;

    logic               adv;
    logic               hazard;

    // Stage 1 -> 2
    logic [gbs_pkg::VAL_W-1:0] mean1;
    logic [gbs_pkg::VAL_W-1:0] var1;
    logic signed [16:0]        d_next;
    logic signed [16:0]        d_reg;
    logic [gbs_pkg::VAL_W-1:0] mean2_reg;
    logic [gbs_pkg::VAL_W-1:0] var2_reg;

    // Stage 2 -> 3
    logic signed [33:0]        dd_full;
    logic signed [33:0]        am_full;
    logic [23:0]               thr_var;
    logic [31:0]               dd_next;
    logic [31:0]               lim_next;
    logic signed [17:0]        am_next;
    logic [31:0]               dd_reg;
    logic [31:0]               lim_reg;
    logic signed [17:0]        am_reg;
    logic [gbs_pkg::VAL_W-1:0] mean3_reg;
    logic [gbs_pkg::VAL_W-1:0] var3_reg;

    // Stage 3 -> 4
    logic signed [18:0]        nm_full;
    logic [gbs_pkg::VAL_W-1:0] nm_next;
    logic signed [24:0]        e_next;
    logic                      fg_next;
    logic                      fg4_reg;
    logic [gbs_pkg::VAL_W-1:0] nm4_reg;
    logic signed [24:0]        e4_reg;
    logic [gbs_pkg::VAL_W-1:0] var4_reg;

    // Stage 4 -> 5
    logic signed [41:0]        av_full;
    logic signed [25:0]        av_next;
    logic                      fg5_reg;
    logic [gbs_pkg::VAL_W-1:0] nm5_reg;
    logic signed [25:0]        av5_reg;
    logic [gbs_pkg::VAL_W-1:0] var5_reg;

    // Stage 5 -> store and output
    logic signed [25:0]        nv;
    logic signed [25:0]        nv_hi;
    logic signed [25:0]        max_s;
    logic signed [25:0]        min_s;
    logic [gbs_pkg::VAL_W-1:0] mean_wr;
    logic [gbs_pkg::VAL_W-1:0] var_wr;
    logic                      mem_we;

    always_comb
    begin
        adv = !out_valid_reg || !out_stall;

        // An entry still on its way to the store must land before it is read again.
        hazard = 1'b0;
        for (int i = 1; i <= STAGES; i++)
        begin
            if (valid_reg[i] && cmd_reg[i].wr_en &&
                cmd_reg[i].pixel_index == head.pixel_index)
            begin
                hazard = 1'b1;
            end
        end
        pop = adv && head_valid && !hazard;

        mean1  = mem_rd_reg[2*gbs_pkg::VAL_W-1:gbs_pkg::VAL_W];
        var1   = mem_rd_reg[gbs_pkg::VAL_W-1:0];
        d_next = $signed({1'b0, mean1}) - $signed({1'b0, cmd_reg[1].pixel, 8'h00});

        dd_full  = d_reg * d_reg;
        dd_next  = dd_full[31:0];
        am_full  = $signed({1'b0, cfg.learning_rate}) * d_reg;
        am_next  = am_full[33:16];
        thr_var  = cfg.match_threshold * var2_reg;
        lim_next = {thr_var, 8'h00};

        fg_next = (dd_reg > lim_reg);
        nm_full = $signed({3'b000, mean3_reg}) - am_reg;
        if (nm_full[18])
        begin
            nm_next = '0;
        end
        else if (|nm_full[17:16])
        begin
            nm_next = '1;
        end
        else
        begin
            nm_next = nm_full[15:0];
        end
        e_next = $signed({1'b0, dd_reg[31:8]}) - $signed({9'b0, var3_reg});

        av_full = $signed({1'b0, cfg.learning_rate}) * e4_reg;
        av_next = av_full[41:16];

        // The lower clamp is applied last, so it wins when the limits cross.
        nv    = $signed({10'b0, var5_reg}) + av5_reg;
        max_s = $signed({10'b0, cfg.variance_ceil});
        min_s = $signed({10'b0, cfg.variance_floor});
        nv_hi = (nv > max_s) ? max_s : nv;
        if (nv_hi < min_s)
        begin
            nv_hi = min_s;
        end

        if (cmd_reg[STAGES].load)
        begin
            mean_wr = {cmd_reg[STAGES].pixel, 8'h00};
            var_wr  = cfg.initial_variance;
        end
        else
        begin
            mean_wr = nm5_reg;
            var_wr  = nv_hi[15:0];
        end
        mem_we = adv && valid_reg[STAGES] && cmd_reg[STAGES].wr_en;

        out_data_next.foreground = cmd_reg[STAGES].wr_en && !cmd_reg[STAGES].load && fg5_reg;
        out_data_next.out_index  = cmd_reg[STAGES].pixel_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[STAGES-1:1], pop};
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg[1] <= head;
            for (int i = 2; i <= STAGES; i++)
            begin
                cmd_reg[i] <= cmd_reg[i-1];
            end

            d_reg     <= d_next;
            mean2_reg <= mean1;
            var2_reg  <= var1;

            dd_reg    <= dd_next;
            lim_reg   <= lim_next;
            am_reg    <= am_next;
            mean3_reg <= mean2_reg;
            var3_reg  <= var2_reg;

            fg4_reg  <= fg_next;
            nm4_reg  <= nm_next;
            e4_reg   <= e_next;
            var4_reg <= var3_reg;

            fg5_reg  <= fg4_reg;
            nm5_reg  <= nm4_reg;
            av5_reg  <= av_next;
            var5_reg <= var4_reg;

            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem_rd_reg <= model_mem[head.pixel_index[gbs_pkg::ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            model_mem[cmd_reg[STAGES].pixel_index[gbs_pkg::ADDR_W-1:0]] <= {mean_wr, var_wr};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_read_of_landing_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop && mem_we |-> cmd_reg[STAGES].pixel_index != head.pixel_index)
        else $error("store read and written at the same entry in one cycle");

    a_variance_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !cmd_reg[STAGES].load && cfg.variance_floor <= cfg.variance_ceil
        |-> var_wr >= cfg.variance_floor && var_wr <= cfg.variance_ceil)
        else $error("updated variance outside its limits");

    a_pipeline_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg) && out_valid_reg)
        else $error("pipeline moved while the output beat was stalled");

endmodule

@@ design/gaussian_background_subtract_unit.sv @@
// A beat accepted into the queue passes the queue, the pipeline stages and the output register.
// Throughput: one pixel per cycle while the output is not stalled; a pixel index repeated within five beats
// waits until the earlier update of that entry has been written to the model store.
// Reset clears the queue, the pipeline and the first-frame flag and loads the default settings.
// The mean and variance stores are not cleared; the first frame loads every entry it touches.
module gaussian_background_subtract_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  gbs_pkg::gbs_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output gbs_pkg::gbs_out_t                  out_data,
    input  logic                               cfg_write,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gbs_pkg::gbs_cfg_t cfg_reg;
    logic              head_valid;
    gbs_pkg::gbs_cmd_t head;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate    <= gbs_pkg::RST_LEARNING_RATE;
            cfg_reg.match_threshold  <= gbs_pkg::RST_MATCH_THRESHOLD;
            cfg_reg.initial_variance <= gbs_pkg::RST_INITIAL_VARIANCE;
            cfg_reg.variance_floor   <= gbs_pkg::RST_VARIANCE_FLOOR;
            cfg_reg.variance_ceil    <= gbs_pkg::RST_VARIANCE_CEIL;
        end
        else if (cfg_write)
        begin
            case (gbs_pkg::cfg_reg_t'(cfg_index))
                gbs_pkg::REG_LEARNING_RATE:    cfg_reg.learning_rate    <= cfg_data;
                gbs_pkg::REG_MATCH_THRESHOLD:
                begin
                    cfg_reg.match_threshold <= cfg_data[gbs_pkg::THR_W-1:0];
                end
                gbs_pkg::REG_INITIAL_VARIANCE: cfg_reg.initial_variance <= cfg_data;
                gbs_pkg::REG_VARIANCE_FLOOR:   cfg_reg.variance_floor   <= cfg_data;
                gbs_pkg::REG_VARIANCE_CEIL:    cfg_reg.variance_ceil    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    gbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

@@ bench/tb_gaussian_background_subtract_unit.sv @@
// Self-checking testbench for the Gaussian background subtraction unit with its own pixel model.
module tb_gaussian_background_subtract_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES    = 16;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  SPARE_REG_FIRST = int'(gbs_pkg::REG_VARIANCE_CEIL) + 1;
    localparam int  SPARE_REG_LAST  = (1 << gbs_pkg::CFG_IDX_W) - 1;
    localparam longint TIMEOUT_NS   = 4_000_000;
    localparam logic [gbs_pkg::IDX_W-1:0] LAST_INDEX = {gbs_pkg::IDX_W{1'b1}};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    gbs_pkg::gbs_in_t               in_data;
    logic                           out_valid;
    logic                           out_stall;
    gbs_pkg::gbs_out_t              out_data;
    logic                           cfg_write;
    logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data;

    // Model of the block: per-pixel statistics, first-frame flag and settings.
    logic [gbs_pkg::VAL_W-1:0] mean_mem [int unsigned];
    logic [gbs_pkg::VAL_W-1:0] var_mem  [int unsigned];
    logic                      model_ready;
    gbs_pkg::gbs_cfg_t         cfg_shadow;

    gbs_pkg::gbs_out_t         predicted_labels [$];
    logic [gbs_pkg::IDX_W-1:0] index_pool [$];

    bit tx_idle_on;
    bit rx_idle_on;
    int hold_cycles;
    int error_count;

    gaussian_background_subtract_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic gbs_pkg::gbs_out_t classify_pixel(input gbs_pkg::gbs_in_t px);
        gbs_pkg::gbs_out_t res;
        longint            mean, vari, alpha, thr, vmin, vmax;
        longint            pix_q, d, dd, lim, d2, nm, nv;
        int unsigned       key;
        key = 32'(px.pixel_index);
        res.foreground = 1'b0;
        res.out_index  = px.pixel_index;
        if (!model_ready)
        begin
            mean_mem[key] = {px.pixel, 8'h00};
            var_mem[key]  = cfg_shadow.initial_variance;
        end
        else
        begin
            mean  = longint'(mean_mem[key]);
            vari  = longint'(var_mem[key]);
            alpha = longint'(cfg_shadow.learning_rate);
            thr   = longint'(cfg_shadow.match_threshold);
            vmin  = longint'(cfg_shadow.variance_floor);
            vmax  = longint'(cfg_shadow.variance_ceil);
            pix_q = longint'({px.pixel, 8'h00});
            d     = mean - pix_q;
            dd    = d * d;
            lim   = (thr * vari) <<< 8;
            res.foreground = (dd > lim);
            d2 = dd >>> 8;
            // Arithmetic shifts of the Q.24 products round toward minus infinity.
            nm = mean - ((alpha * d) >>> 16);
            if (nm < 0)
                nm = 0;
            if (nm > 65535)
                nm = 65535;
            nv = vari + ((alpha * (d2 - vari)) >>> 16);
            if (nv > vmax)
                nv = vmax;
            if (nv < vmin)
                nv = vmin;
            mean_mem[key] = nm[gbs_pkg::VAL_W-1:0];
            var_mem[key]  = nv[gbs_pkg::VAL_W-1:0];
        end
        if (px.frame_end)
            model_ready = 1'b1;
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        $display("%0t: %s", $time, msg);
    endfunction

    always @(posedge clk)
    begin
        gbs_pkg::gbs_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_labels.size() == 0)
                note_failure($sformatf("unexpected result beat, actual index %0d fg %0b",
                                       out_data.out_index, out_data.foreground));
            else
            begin
                want = predicted_labels.pop_front();
                if (out_data.out_index !== want.out_index)
                    note_failure($sformatf("out_index mismatch, expected %0d, actual %0d",
                                           want.out_index, out_data.out_index));
                if (out_data.foreground !== want.foreground)
                    note_failure($sformatf(
                        "foreground mismatch at index %0d, expected %0b, actual %0b",
                        want.out_index, want.foreground, out_data.foreground));
            end
        end
    end

    // Result side: random stall per beat, plus a long hold-off on request.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else
            begin
                gap = rx_idle_on ? $urandom_range(0, 14) : 0;
                if (gap > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (gap - 1) @(negedge clk);
                end
                @(negedge clk);
                out_stall <= 1'b0;
                do
                    @(posedge clk);
                while (!out_valid && hold_cycles == 0);
            end
        end
    end

    task automatic send_pixel(input logic [gbs_pkg::PIX_W-1:0] pix,
                              input logic [gbs_pkg::IDX_W-1:0] idx, input logic fe);
        gbs_pkg::gbs_in_t beat;
        int               gap;
        beat.pixel       = pix;
        beat.pixel_index = idx;
        beat.frame_end   = fe;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        predicted_labels.push_back(classify_pixel(beat));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_labels.size() != 0)
            @(posedge clk);
        // The store write-back of the last beat lands by the time its result is shown.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gbs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            gbs_pkg::REG_LEARNING_RATE:    cfg_shadow.learning_rate    = value;
            gbs_pkg::REG_MATCH_THRESHOLD:
                cfg_shadow.match_threshold = value[gbs_pkg::THR_W-1:0];
            gbs_pkg::REG_INITIAL_VARIANCE: cfg_shadow.initial_variance = value;
            gbs_pkg::REG_VARIANCE_FLOOR:   cfg_shadow.variance_floor   = value;
            gbs_pkg::REG_VARIANCE_CEIL:    cfg_shadow.variance_ceil    = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [gbs_pkg::VAL_W-1:0] lr,
                                input logic [gbs_pkg::THR_W-1:0] thr,
                                input logic [gbs_pkg::VAL_W-1:0] iv,
                                input logic [gbs_pkg::VAL_W-1:0] vmin,
                                input logic [gbs_pkg::VAL_W-1:0] vmax);
        logic [gbs_pkg::CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = gbs_pkg::CFG_DATA_W'($urandom);
        write_reg(gbs_pkg::REG_LEARNING_RATE, lr);
        // Upper data bits of the threshold write must be dropped.
        write_reg(gbs_pkg::REG_MATCH_THRESHOLD,
                  {junk[gbs_pkg::CFG_DATA_W-1:gbs_pkg::THR_W], thr});
        write_reg(gbs_pkg::REG_INITIAL_VARIANCE, iv);
        write_reg(gbs_pkg::REG_VARIANCE_FLOOR, vmin);
        write_reg(gbs_pkg::REG_VARIANCE_CEIL, vmax);
        write_reg(gbs_pkg::CFG_IDX_W'($urandom_range(SPARE_REG_FIRST, SPARE_REG_LAST)), junk);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_random_traffic(input int count);
        logic [gbs_pkg::IDX_W-1:0] idx;
        logic [gbs_pkg::IDX_W-1:0] prev_idx;
        int                        sel;
        int                        p;
        prev_idx = index_pool[0];
        repeat (count)
        begin
            // Short repeats of one index exercise the read-after-write path.
            if ($urandom_range(0, 7) == 0)
                idx = prev_idx;
            else
                idx = index_pool[$urandom_range(0, index_pool.size() - 1)];
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                p = int'(mean_mem[32'(idx)][gbs_pkg::VAL_W-1:8]) +
                    int'($urandom_range(0, 12)) - 6;
                if (p < 0)
                    p = 0;
                if (p > 255)
                    p = 255;
            end
            else if (sel < 8)
                p = $urandom_range(0, 255);
            else
                p = $urandom_range(0, 1) ? 255 : 0;
            send_pixel(gbs_pkg::PIX_W'(p), idx, $urandom_range(0, 31) == 0);
            prev_idx = idx;
        end
    endtask

    task automatic test_first_frame();
        logic [gbs_pkg::VAL_W-1:0] iv;
        logic [gbs_pkg::IDX_W-1:0] idx;
        int                        pick;
        pick = $urandom_range(0, 2);
        iv = (pick == 0) ? '0 : (pick == 1) ? {gbs_pkg::VAL_W{1'b1}} :
             gbs_pkg::VAL_W'($urandom);
        apply_config(gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD, iv,
                     gbs_pkg::RST_VARIANCE_FLOOR, gbs_pkg::RST_VARIANCE_CEIL);
        index_pool = '{19'h0, LAST_INDEX, 19'h2AAAA, 19'h55555, 19'h1, 19'h2, 19'h3};
        send_pixel(8'd0,   19'h0,      1'b0);
        send_pixel(8'd255, LAST_INDEX, 1'b0);
        send_pixel(8'hAA,  19'h2AAAA,  1'b0);
        send_pixel(8'h55,  19'h55555,  1'b0);
        send_pixel(8'd128, 19'h1,      1'b0);
        send_pixel(8'd77,  19'h1,      1'b0);
        send_pixel(8'd200, 19'h2,      1'b0);
        send_pixel(8'd10,  19'h3,      1'b0);
        for (int i = 0; i < 72; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                idx = index_pool[$urandom_range(0, index_pool.size() - 1)];
            else
            begin
                idx = gbs_pkg::IDX_W'($urandom);
                index_pool.push_back(idx);
            end
            send_pixel(gbs_pkg::PIX_W'($urandom), idx, i == 71);
        end
    endtask

    task automatic test_directed_cases();
        apply_config(gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD,
                     gbs_pkg::RST_INITIAL_VARIANCE, gbs_pkg::RST_VARIANCE_FLOOR,
                     gbs_pkg::RST_VARIANCE_CEIL);
        send_pixel(8'd255, 19'h0,      1'b0);
        send_pixel(8'd0,   LAST_INDEX, 1'b0);
        send_pixel(8'hAA,  19'h2AAAA,  1'b0);
        send_pixel(8'h56,  19'h55555,  1'b1);
        tx_idle_on = 1'b0;
        send_pixel(8'd128, 19'h1, 1'b0);
        send_pixel(8'd128, 19'h1, 1'b0);
        send_pixel(8'd128, 19'h1, 1'b0);
        tx_idle_on = 1'b1;
        // With a zero threshold only an exact match is background.
        apply_config(gbs_pkg::RST_LEARNING_RATE, 8'd0, gbs_pkg::RST_INITIAL_VARIANCE,
                     gbs_pkg::RST_VARIANCE_FLOOR, gbs_pkg::RST_VARIANCE_CEIL);
        send_pixel(8'd200, 19'h2, 1'b0);
        send_pixel(8'd11,  19'h3, 1'b0);
        apply_config(16'd0, 8'd1, 16'd0, 16'd0, {gbs_pkg::VAL_W{1'b1}});
        send_pixel(8'd50, 19'h2, 1'b0);
        send_pixel(8'd0,  19'h0, 1'b0);
        apply_config({gbs_pkg::VAL_W{1'b1}}, 8'd255, {gbs_pkg::VAL_W{1'b1}}, 16'd0,
                     {gbs_pkg::VAL_W{1'b1}});
        send_pixel(8'd255, 19'h0,      1'b0);
        send_pixel(8'd0,   19'h0,      1'b0);
        send_pixel(8'd128, LAST_INDEX, 1'b0);
        // Crossed clamps leave the stored variance at the lower bound.
        apply_config(gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD,
                     gbs_pkg::RST_INITIAL_VARIANCE, 16'd40000, 16'd100);
        send_pixel(8'd5,   19'h1, 1'b0);
        send_pixel(8'd250, 19'h1, 1'b0);
        send_pixel(8'd250, 19'h1, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [gbs_pkg::VAL_W-1:0] vmin;
        apply_config(gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD,
                     gbs_pkg::RST_INITIAL_VARIANCE, gbs_pkg::RST_VARIANCE_FLOOR,
                     gbs_pkg::RST_VARIANCE_CEIL);
        run_random_traffic(250);

        apply_config({gbs_pkg::VAL_W{1'b1}}, 8'd255, gbs_pkg::VAL_W'($urandom), 16'd0,
                     {gbs_pkg::VAL_W{1'b1}});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_traffic(200);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        vmin = gbs_pkg::VAL_W'($urandom_range(0, 30000));
        apply_config(16'd0, 8'd1, gbs_pkg::VAL_W'($urandom), vmin,
                     vmin + gbs_pkg::VAL_W'($urandom_range(0, 30000)));
        run_random_traffic(200);

        apply_config(gbs_pkg::VAL_W'($urandom), gbs_pkg::THR_W'($urandom),
                     gbs_pkg::VAL_W'($urandom), gbs_pkg::VAL_W'($urandom),
                     gbs_pkg::VAL_W'($urandom));
        run_random_traffic(250);

        apply_config(gbs_pkg::VAL_W'($urandom_range(0, 4000)),
                     gbs_pkg::THR_W'($urandom_range(0, 3)),
                     gbs_pkg::VAL_W'($urandom), 16'd0, {gbs_pkg::VAL_W{1'b1}});
        tx_idle_on = 1'b0;
        run_random_traffic(200);
        tx_idle_on = 1'b1;

        apply_config(gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD,
                     gbs_pkg::RST_INITIAL_VARIANCE, gbs_pkg::RST_VARIANCE_FLOOR,
                     gbs_pkg::RST_VARIANCE_CEIL);
        run_random_traffic(250);
    endtask

    // The result side holds off while beats keep coming, so the input must stall.
    task automatic test_input_backpressure();
        wait_idle();
        hold_cycles = HOLD_OFF_CYCLES;
        tx_idle_on  = 1'b0;
        run_random_traffic(60);
        tx_idle_on  = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_cycles = 0;
        error_count = 0;
        model_ready = 1'b0;
        cfg_shadow  = '{gbs_pkg::RST_LEARNING_RATE, gbs_pkg::RST_MATCH_THRESHOLD,
                        gbs_pkg::RST_INITIAL_VARIANCE, gbs_pkg::RST_VARIANCE_FLOOR,
                        gbs_pkg::RST_VARIANCE_CEIL};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_frame();
        test_directed_cases();
        test_random_traffic();
        test_input_backpressure();

        wait_idle();
        if (error_count == 0)
            $display("gaussian_background_subtract_unit regression: pass");
        else
            $display("gaussian_background_subtract_unit regression: fail");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("gaussian_background_subtract_unit regression: fail");
        $finish;
    end

endmodule

@@ gaussian_background_subtract_unit.f @@
design/gbs_pkg.sv
design/gbs_front.sv
design/gbs_back.sv
design/gaussian_background_subtract_unit.sv
bench/tb_gaussian_background_subtract_unit.sv
